@@ hdl/bvt_warp_scheduler_core_defines.svh @@
// Assertion macros shared by the scheduler RTL
`ifndef BVT_WARP_SCHEDULER_CORE_DEFINES_SVH
`define BVT_WARP_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication under synchronous active-low reset
`define BVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under synchronous active-low reset
`define BVT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bvt_pkg.sv @@
package bvt_pkg;

    localparam int THREADS = 8;

    // Request modes
    localparam logic [2:0] MODE_SETUP = 3'd0;
    localparam logic [2:0] MODE_WAKE  = 3'd1;
    localparam logic [2:0] MODE_SLEEP = 3'd2;
    localparam logic [2:0] MODE_PRIO  = 3'd3;
    localparam logic [2:0] MODE_PICK  = 3'd4;

    // Configuration register indexes
    localparam logic CFG_MCU   = 1'b0;
    localparam logic CFG_ALLOW = 1'b1;

    localparam logic [31:0] MCU_RESET   = 32'd2000000;
    localparam logic [7:0]  ALLOW_RESET = 8'd5;
    localparam logic [7:0]  WEIGHT_LO   = 8'd1;
    localparam logic [7:0]  WEIGHT_HI   = 8'd128;
    localparam logic [63:0] RATIO_TOP   = 64'd1024;
    localparam logic [63:0] SIGN64      = 64'h8000_0000_0000_0000;

    typedef enum logic [4:0] {
        S_IDLE, S_SETUP, S_SETUP_WR, S_WAKE, S_WARP_CHK, S_WARP_CMP, S_WARP_SET,
        S_REFRESH, S_REQ, S_REM, S_INS_INIT, S_INS_WALK, S_INS_PUT,
        S_CHG0, S_CHG1, S_CHG2, S_CHG3, S_CHG_APPLY,
        S_PK_HEAD, S_PK_F, S_PK_S, S_PK_CD, S_PK_M1, S_PK_M2, S_PK_M3,
        S_DIV, S_FIN, S_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic [31:0] rem;
    } t_div_rsp;

    // Signed greater-than on two's complement words
    function automatic logic sgt(input logic [63:0] a, input logic [63:0] b);
        return (a ^ SIGN64) > (b ^ SIGN64);
    endfunction

endpackage

@@ hdl/bvt_div.sv @@
module bvt_div import bvt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_q;
    logic [31:0] r_r;
    logic [31:0] r_d;
    logic [32:0] sh;
    logic        ge;
    logic [32:0] n_r;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        sh  = {r_r, r_q[63]};
        ge  = sh >= {1'b0, r_d};
        n_r = ge ? sh - {1'b0, r_d} : sh;
    end

    // Control: one quotient bit per cycle, pulse done after the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q <= i_req.dividend;
            r_r <= '0;
            r_d <= i_req.divisor;
        end else if (r_busy) begin
            r_q <= {r_q[62:0], ge};
            r_r <= n_r[31:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_r;

endmodule

@@ hdl/bvt_warp_scheduler_core.sv @@
// The insert walk and the two 64-step divisions of a pick (charge, deadline) set how
// long a request takes. Only one request is in flight: the next is taken once the
// core is back in idle after the result is taken. Reset (synchronous, active low)
// clears the thread tables and run queue, marks the idle thread running, loads
// config defaults.
`include "bvt_warp_scheduler_core_defines.svh"

module bvt_warp_scheduler_core import bvt_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // thread[2:0] now_ticks[66:3] share_weight[74:67] boost_amount[106:75]
    // boost_limit[138:107] cooldown_units[170:139], zero fill above
    input  logic [175:0] s_axis_tdata,
    // mode[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // next_thread[2:0] timer_deadline[66:3] thread_actual_vt[130:67]
    // thread_effective_vt[194:131] queue_length[198:195], zero fill above
    output logic [199:0] m_axis_tdata,
    // next_idle[0] timer_armed[1]
    output logic [1:0]   m_axis_tuser
);

    t_state r_state, n_state, r_ret;

    logic [31:0] r_mcu;
    logic [7:0]  r_allow;

    logic [2:0]  r_mode;
    logic [2:0]  r_a;
    logic [63:0] r_now;
    logic [7:0]  r_w;
    logic [31:0] r_ba, r_bl, r_cdu;
    logic        r_ins, r_force;
    logic [3:0]  r_i;
    logic [63:0] r_key, r_acc, r_prod, r_units, r_cd;
    logic [10:0] r_ratio;

    logic [10:0] r_ratio_tab [THREADS];
    logic [31:0] r_ba_tab    [THREADS];
    logic [31:0] r_bl_tab    [THREADS];
    logic [31:0] r_cd_tab    [THREADS];
    logic        r_wact      [THREADS];
    logic [31:0] r_wrem      [THREADS];
    logic [63:0] r_lunw      [THREADS];
    logic [63:0] r_avt       [THREADS];
    logic [63:0] r_evt       [THREADS];
    logic [63:0] r_crem      [THREADS];
    logic [63:0] r_start     [THREADS];
    logic [2:0]  r_order     [THREADS];
    logic [THREADS-1:0] r_inq;
    logic [3:0]  r_count;
    logic [2:0]  r_run;
    logic        r_run_idle;
    logic [63:0] r_svt;

    logic [2:0]  r_o_nt;
    logic        r_o_idle, r_o_armed;
    logic [63:0] r_o_dl, r_o_avt, r_o_evt;

    logic [2:0]  rd_a;
    logic [63:0] rd_avt, rd_evt, rd_crem, rd_start, rd_lunw, rd_bsext, delta;
    logic [31:0] mcu_eff, mul_a, mul_b;
    logic [7:0]  wc;
    logic        ins_stop, warp_ok_cd;
    logic [2:0]  rem_pos;
    t_state      cont, warp_skip;
    t_div_req    div_req;
    t_div_rsp    div_rsp;

    bvt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Table read port: queue walk follows the order list, otherwise the work slot
    always_comb begin
        rd_a     = (r_state == S_INS_WALK) ? r_order[r_i[2:0]] : r_a;
        rd_avt   = r_avt[rd_a];
        rd_evt   = r_evt[rd_a];
        rd_crem  = r_crem[rd_a];
        rd_start = r_start[rd_a];
        rd_lunw  = r_lunw[rd_a];
        rd_bsext = {{32{r_ba_tab[rd_a][31]}}, r_ba_tab[rd_a]};
        delta    = r_now - rd_start;
        mcu_eff  = (r_mcu == 32'd0) ? 32'd1 : r_mcu;
        wc       = (r_w < WEIGHT_LO) ? WEIGHT_LO : ((r_w > WEIGHT_HI) ? WEIGHT_HI : r_w);
        ins_stop = (r_i == r_count) || sgt(rd_evt, r_key);
        warp_ok_cd = (r_cd_tab[rd_a] == 32'd0) || (rd_lunw == 64'd0) ||
                     ((r_now - rd_lunw) >= r_prod);
        cont      = (r_mode == MODE_PICK) ? S_PK_HEAD : S_FIN;
        warp_skip = r_force ? S_REFRESH : S_FIN;
    end

    // Locate the slot in the queue for removal
    always_comb begin
        rem_pos = '0;
        for (int i = THREADS - 1; i >= 0; i--) begin
            if (r_order[i] == r_a && 4'(i) < r_count) rem_pos = 3'(i);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    unique case (s_axis_tuser)
                        MODE_SETUP: n_state = S_SETUP;
                        MODE_WAKE:  n_state = S_WAKE;
                        MODE_SLEEP: n_state = S_REM;
                        MODE_PRIO:  n_state = S_WARP_CHK;
                        MODE_PICK:  n_state = r_run_idle ? S_PK_HEAD : S_CHG0;
                        default:    n_state = S_OUT;
                    endcase
                end
            end
            S_SETUP:    n_state = S_DIV;
            S_SETUP_WR: n_state = S_REM;
            S_WAKE:     n_state = S_WARP_CHK;
            S_WARP_CHK: begin
                if (r_wact[rd_a] || r_ba_tab[rd_a] == 32'd0 || r_ba_tab[rd_a][31])
                    n_state = warp_skip;
                else
                    n_state = S_WARP_CMP;
            end
            S_WARP_CMP:  n_state = warp_ok_cd ? S_WARP_SET : warp_skip;
            S_WARP_SET:  n_state = S_REFRESH;
            S_REFRESH:   n_state = S_REQ;
            S_REQ:       n_state = (r_force || r_inq[r_a]) ? S_REM : cont;
            S_REM:       n_state = r_ins ? S_INS_INIT : cont;
            S_INS_INIT:  n_state = S_INS_WALK;
            S_INS_WALK:  n_state = ins_stop ? S_INS_PUT : S_INS_WALK;
            S_INS_PUT:   n_state = cont;
            S_CHG0:      n_state = (r_now > rd_start) ? S_CHG1 : S_CHG_APPLY;
            S_CHG1:      n_state = S_CHG2;
            S_CHG2:      n_state = S_DIV;
            S_CHG3:      n_state = S_CHG_APPLY;
            S_CHG_APPLY: n_state = S_REFRESH;
            S_PK_HEAD:   n_state = (r_count == 4'd0) ? S_OUT : S_PK_F;
            S_PK_F:      n_state = (r_count >= 4'd2) ? S_PK_S : S_OUT;
            S_PK_S:      n_state = S_DIV;
            S_PK_CD:     n_state = S_PK_M1;
            S_PK_M1:     n_state = S_PK_M2;
            S_PK_M2:     n_state = S_PK_M3;
            S_PK_M3:     n_state = S_OUT;
            S_DIV:       n_state = div_rsp.done ? r_ret : S_DIV;
            S_FIN:       n_state = S_OUT;
            S_OUT:       n_state = m_axis_tready ? S_IDLE : S_OUT;
            default:     n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshakes, multiplier operands, divider request
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        m_axis_tvalid = (r_state == S_OUT);
        o_cfg_ready   = 1'b1;
        mul_a   = '0;
        mul_b   = '0;
        div_req = '0;
        case (r_state)
            S_WARP_CHK: begin
                mul_a = r_cd_tab[rd_a];
                mul_b = mcu_eff;
            end
            S_CHG0: begin
                mul_a = delta[31:0];
                mul_b = {21'd0, r_ratio_tab[rd_a]};
            end
            S_CHG1: begin
                mul_a = delta[63:32];
                mul_b = {21'd0, r_ratio_tab[rd_a]};
            end
            S_PK_M1: begin
                mul_a = r_cd[31:0];
                mul_b = mcu_eff;
            end
            S_PK_M2: begin
                mul_a = r_cd[63:32];
                mul_b = mcu_eff;
            end
            S_SETUP: begin
                div_req.start    = 1'b1;
                div_req.dividend = RATIO_TOP;
                div_req.divisor  = {24'd0, wc};
            end
            S_CHG2: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_acc + {r_prod[31:0], 32'd0} + rd_crem;
                div_req.divisor  = mcu_eff;
            end
            S_PK_S: begin
                div_req.start    = 1'b1;
                div_req.dividend = rd_evt - r_key;
                div_req.divisor  = {21'd0, (r_ratio == 11'd0) ? 11'd1 : r_ratio};
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // Shared multiplier, product registered
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Queue order list: read only below the count, so no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_REM && r_inq[r_a]) begin
            for (int i = 0; i < THREADS - 1; i++) begin
                if (3'(i) >= rem_pos) r_order[i] <= r_order[i + 1];
            end
        end else if (r_state == S_INS_PUT) begin
            for (int i = 1; i < THREADS; i++) begin
                if (4'(i) > r_i) r_order[i] <= r_order[i - 1];
            end
            r_order[r_i[2:0]] <= r_a;
        end
    end

    // Request fields and working registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_mode  <= s_axis_tuser;
            r_a     <= (s_axis_tuser == MODE_PICK) ? r_run : s_axis_tdata[2:0];
            r_now   <= s_axis_tdata[66:3];
            r_w     <= s_axis_tdata[74:67];
            r_ba    <= s_axis_tdata[106:75];
            r_bl    <= s_axis_tdata[138:107];
            r_cdu   <= s_axis_tdata[170:139];
            r_ins   <= (s_axis_tuser == MODE_WAKE) || (s_axis_tuser == MODE_PRIO) ||
                       (s_axis_tuser == MODE_PICK);
            r_force <= (s_axis_tuser == MODE_WAKE);
        end
        unique case (r_state)
            S_SETUP:    r_ret <= S_SETUP_WR;
            S_CHG2:     r_ret <= S_CHG3;
            S_PK_S:     r_ret <= S_PK_CD;
            default:    r_ret <= r_ret;
        endcase
        if (r_state == S_INS_INIT) begin
            r_key <= rd_evt;
            r_i   <= '0;
        end
        if (r_state == S_INS_WALK && !ins_stop) r_i <= r_i + 4'd1;
        if (r_state == S_CHG0) r_units <= '0;
        if (r_state == S_CHG1) r_acc <= r_prod;
        if (r_state == S_CHG3) r_units <= div_rsp.quot;
        if (r_state == S_PK_HEAD) r_a <= r_order[0];
        if (r_state == S_PK_F) begin
            r_key   <= rd_evt;
            r_ratio <= r_ratio_tab[rd_a];
            if (r_count >= 4'd2) r_a <= r_order[1];
        end
        if (r_state == S_PK_CD) r_cd <= div_rsp.quot + {56'd0, r_allow};
        if (r_state == S_PK_M2) r_acc <= r_prod;
    end

    // Control state, configuration, thread tables and run queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mcu      <= MCU_RESET;
            r_allow    <= ALLOW_RESET;
            r_inq      <= '0;
            r_count    <= '0;
            r_run      <= '0;
            r_run_idle <= 1'b1;
            r_svt      <= '0;
            for (int i = 0; i < THREADS; i++) begin
                r_ratio_tab[i] <= '0;
                r_ba_tab[i]    <= '0;
                r_bl_tab[i]    <= '0;
                r_cd_tab[i]    <= '0;
                r_wact[i]      <= 1'b0;
                r_wrem[i]      <= '0;
                r_lunw[i]      <= '0;
                r_avt[i]       <= '0;
                r_evt[i]       <= '0;
                r_crem[i]      <= '0;
                r_start[i]     <= '0;
            end
        end else begin
            r_state <= n_state;

            // Take configuration writes
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_MCU) r_mcu <= i_cfg_data;
                else r_allow <= i_cfg_data[7:0];
            end

            unique case (r_state)
                S_SETUP_WR: begin
                    r_ratio_tab[r_a] <= div_rsp.quot[10:0];
                    r_ba_tab[r_a]    <= r_ba;
                    r_bl_tab[r_a]    <= r_bl;
                    r_cd_tab[r_a]    <= r_cdu;
                    r_wact[r_a]      <= 1'b0;
                    r_wrem[r_a]      <= '0;
                    r_lunw[r_a]      <= '0;
                    r_crem[r_a]      <= '0;
                end
                S_WAKE: begin
                    // Pull a long sleeper up to the scheduler time
                    if (!sgt(rd_avt, r_svt - {56'd0, r_allow})) r_avt[r_a] <= r_svt;
                end
                S_WARP_SET: begin
                    r_wact[r_a] <= 1'b1;
                    r_wrem[r_a] <= (r_bl_tab[r_a] != 32'd0) ? r_bl_tab[r_a] : 32'd1;
                end
                S_REFRESH: begin
                    r_evt[r_a] <= r_wact[r_a] ? rd_avt - rd_bsext : rd_avt;
                end
                S_REM: begin
                    if (r_inq[r_a]) begin
                        r_inq[r_a] <= 1'b0;
                        r_count    <= r_count - 4'd1;
                    end
                end
                S_INS_PUT: begin
                    r_inq[r_a] <= 1'b1;
                    r_count    <= r_count + 4'd1;
                end
                S_CHG3: begin
                    r_crem[r_a] <= {32'd0, div_rsp.rem};
                end
                S_CHG_APPLY: begin
                    // Charge units and run down the warp
                    r_avt[r_a] <= rd_avt + r_units;
                    if (r_wact[r_a] && r_units != 64'd0) begin
                        if (r_units >= {32'd0, r_wrem[r_a]}) begin
                            r_wact[r_a] <= 1'b0;
                            r_wrem[r_a] <= '0;
                            r_lunw[r_a] <= r_now;
                        end else begin
                            r_wrem[r_a] <= r_wrem[r_a] - r_units[31:0];
                        end
                    end
                end
                S_PK_HEAD: begin
                    if (r_count == 4'd0) r_run_idle <= 1'b1;
                end
                S_PK_F: begin
                    r_svt        <= rd_avt;
                    r_start[r_a] <= r_now;
                    r_run        <= r_a;
                    r_run_idle   <= 1'b0;
                end
                default: begin
                    r_run <= r_run;
                end
            endcase
        end
    end

    // Result fields
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_o_nt    <= '0;
            r_o_idle  <= 1'b0;
            r_o_armed <= 1'b0;
            r_o_dl    <= '0;
            r_o_avt   <= '0;
            r_o_evt   <= '0;
        end
        if (r_state == S_FIN) begin
            r_o_avt <= rd_avt;
            r_o_evt <= rd_evt;
        end
        if (r_state == S_PK_HEAD && r_count == 4'd0) r_o_idle <= 1'b1;
        if (r_state == S_PK_F) begin
            r_o_nt  <= r_a;
            r_o_avt <= rd_avt;
            r_o_evt <= rd_evt;
        end
        if (r_state == S_PK_M3) begin
            r_o_armed <= 1'b1;
            r_o_dl    <= r_now + r_acc + {r_prod[31:0], 32'd0};
        end
    end

    assign m_axis_tdata = {1'b0, r_count, r_o_evt, r_o_avt, r_o_dl, r_o_nt};
    assign m_axis_tuser = {r_o_armed, r_o_idle};

    `BVT_ASSERT_IMP(a_count_matches, i_clk, i_rst_n, 1'b1, $countones(r_inq) == int'(r_count), "queue count disagrees with membership")
    `BVT_ASSERT_IMP(a_one_side, i_clk, i_rst_n, s_axis_tready, !m_axis_tvalid, "ready while a result waits")
    `BVT_ASSERT_NXT(a_back_idle, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready, s_axis_tready, "not ready after result taken")

endmodule
